// File: rtl/core/csmg_pkg.sv
// Shared types, constants and fixed-point helper functions for the cubic
// spline move generator. Depends on nothing; every other file imports it.
`default_nettype none

package csmg_pkg;

  localparam int unsigned ANG_W  = 16;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned CLK_W  = 25;
  localparam int unsigned SPD_W  = 15;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned COEF_W = 40;
  localparam int unsigned U_W    = 44;
  localparam int unsigned ACC_W  = 36;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CFG_W  = 24;

  localparam logic [IDX_W-1:0] REG_SPEED    = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_TIME = 2'd1;
  localparam logic [IDX_W-1:0] REG_TICK     = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [SPD_W-1:0]  SPEED_RST    = 15'd12861;
  localparam logic [TIME_W-1:0] MIN_TIME_RST = 24'd327680;
  localparam logic [TICK_W-1:0] TICK_RST     = 16'd328;

  localparam logic signed [ANG_W-1:0] HOME_POS [8] = '{
    16'sd0, 16'sd3686, 16'sd7168, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  typedef struct packed {
    logic need;
    logic coef;
    logic tick;
  } lane_cmd_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] need;
  } lane_sts_t;

  typedef enum logic [3:0] {
    L_IDLE, L_NEED, L_QA, L_QB, L_C, L_U, L_D, L_E, L_G, L_P, L_V, L_FIN
  } lane_st_t;

  typedef enum logic [2:0] {
    T_IDLE, T_NEED, T_MERGE, T_CGO, T_COEF, T_TICK, T_OUT
  } top_st_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat_from(input logic neg, input logic [63:0] m,
                                                  input int unsigned w);
    logic [63:0] lim;
    lim = (64'd1 << (w - 1)) - 64'd1;
    if (m > lim) return neg ? $signed(~lim) : $signed(lim);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp_s(input logic signed [63:0] v,
                                                 input int unsigned w);
    logic [63:0] lim;
    lim = (64'd1 << (w - 1)) - 64'd1;
    if (v > $signed(lim)) return $signed(lim);
    if (v < $signed(~lim)) return $signed(~lim);
    return v;
  endfunction

  function automatic logic [63:0] rnd_shr(input logic [63:0] p, input int unsigned sh);
    return (p >> sh) + ((p >> (sh - 1)) & 64'd1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/csmg_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 24-bit
// divisor. Uses csmg_pkg for widths.
`default_nettype none

module csmg_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [csmg_pkg::NUM_W-1:0] num,
  input  wire logic [csmg_pkg::TIME_W-1:0] den,
  output logic      [csmg_pkg::NUM_W-1:0] quo,
  output logic      [csmg_pkg::TIME_W-1:0] rem,
  output logic                            done
);
  import csmg_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  num_r;
  logic [TIME_W-1:0] rem_r, den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [TIME_W:0]   rs;
  logic              ge;

  assign rs = {rem_r, num_r[NUM_W-1]};
  assign ge = rs >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(NUM_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? TIME_W'(rs - {1'b0, den_r}) : rs[TIME_W-1:0];
    end
  end

  assign quo  = num_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

`default_nettype wire

// File: rtl/core/csmg_mul.sv
// Sign-magnitude multiplier, 24 by 40 bits, built from one 24 by 20 bit
// product used for the low and then the high half. Uses csmg_pkg for widths.
`default_nettype none

module csmg_mul (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [csmg_pkg::CLK_W-1:0]  a,
  input  wire logic signed [csmg_pkg::COEF_W-1:0] b,
  output logic             [csmg_pkg::NUM_W-1:0]  p,
  output logic                                    neg,
  output logic                                    done
);
  import csmg_pkg::*;

  localparam int unsigned AW = CLK_W - 1;
  localparam int unsigned BW = COEF_W;
  localparam int unsigned HW = BW / 2;
  localparam int unsigned PW = AW + HW;
  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  logic [AW-1:0]    am_r;
  logic [BW-1:0]    bm_r;
  logic             neg_r, busy_r, done_r;
  logic [1:0]       ph_r;
  logic [PW-1:0]    lo_r, hi_r, prod;
  logic [NUM_W-1:0] p_r;

  assign prod = PW'(am_r) * PW'((ph_r == PH_LO) ? bm_r[HW-1:0] : bm_r[BW-1:HW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_LO;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= PH_LO;
      end else if (busy_r) begin
        ph_r <= ph_r + 1'b1;
        if (ph_r == PH_SUM) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= a[CLK_W-1] ? AW'(-a) : AW'(a);
      bm_r  <= b[BW-1] ? BW'(-b) : BW'(b);
      neg_r <= a[CLK_W-1] ^ b[BW-1];
    end else if (busy_r) begin
      unique case (ph_r)
        PH_LO:   lo_r <= prod;
        PH_HI:   hi_r <= prod;
        PH_SUM:  p_r  <= NUM_W'(lo_r) + (NUM_W'(hi_r) << HW);
        default: ;
      endcase
    end
  end

  assign p    = p_r;
  assign neg  = neg_r;
  assign done = done_r;

endmodule

`default_nettype wire

// File: rtl/core/csmg_lane.sv
// One joint lane: holds the joint state and cubic coefficients and runs the
// move-time, coefficient and evaluation steps. Uses csmg_pkg, csmg_div, csmg_mul.
`default_nettype none

module csmg_lane #(
  parameter int unsigned LANE = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire csmg_pkg::lane_cmd_t                cmd,
  output csmg_pkg::lane_sts_t                     sts,
  input  wire logic signed [csmg_pkg::ANG_W-1:0]  tgt_in,
  input  wire logic        [csmg_pkg::SPD_W-1:0]  spd,
  input  wire logic        [csmg_pkg::TIME_W-1:0] tm,
  input  wire logic signed [csmg_pkg::CLK_W-1:0]  t,
  output logic signed      [csmg_pkg::ANG_W-1:0]  pos,
  output logic signed      [csmg_pkg::ANG_W-1:0]  vel
);
  import csmg_pkg::*;

  localparam logic [63:0] CAP31 = (64'd1 << 31) - 64'd1;
  localparam logic [63:0] CAP43 = (64'd1 << 43) - 64'd1;

  lane_st_t state_r, state_nxt;
  logic     issued_r;

  logic signed [ANG_W-1:0]  pos_r, vel_r, tgt_r, cst_r;
  logic signed [COEF_W-1:0] csq_r, ccu_r, e_r, g_r;
  logic signed [ACC_W-1:0]  a_r, b_r;
  logic signed [U_W-1:0]    u_r;
  logic [TIME_W-1:0]        need_r;

  logic signed [ANG_W:0] dq;
  logic [ANG_W:0]        dq_mag;
  logic [63:0]           mn;

  logic              is_div, div_start, div_done, div_neg;
  logic [NUM_W-1:0]  div_num, div_q;
  logic [TIME_W-1:0] div_den, div_rem;
  int unsigned       div_w;
  logic              mul_start, mul_done, mul_neg;
  logic signed [COEF_W-1:0] mul_b;
  logic [NUM_W-1:0]  mul_p;
  int unsigned       mul_sh;
  logic              unit_done;

  logic [63:0]        q_rnd, q_ceil;
  logic signed [63:0] qs, mp;

  assign dq     = (ANG_W + 1)'(pos_r) - (ANG_W + 1)'(tgt_r);
  assign dq_mag = dq[ANG_W] ? (ANG_W + 1)'(-dq) : (ANG_W + 1)'(dq);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: begin
        priority if (cmd.need) state_nxt = L_NEED;
        else if (cmd.coef) state_nxt = (tm == '0) ? L_FIN : L_QA;
        else if (cmd.tick) state_nxt = L_E;
      end
      L_NEED:  if (issued_r && unit_done) state_nxt = L_FIN;
      L_QA:    if (issued_r && unit_done) state_nxt = L_QB;
      L_QB:    if (issued_r && unit_done) state_nxt = L_C;
      L_C:     if (issued_r && unit_done) state_nxt = L_U;
      L_U:     if (issued_r && unit_done) state_nxt = L_D;
      L_D:     if (issued_r && unit_done) state_nxt = L_FIN;
      L_E:     if (issued_r && unit_done) state_nxt = L_G;
      L_G:     if (issued_r && unit_done) state_nxt = L_P;
      L_P:     if (issued_r && unit_done) state_nxt = L_V;
      L_V:     if (issued_r && unit_done) state_nxt = L_FIN;
      L_FIN:   state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    is_div  = 1'b0;
    div_num = '0;
    div_den = tm;
    div_neg = 1'b0;
    div_w   = COEF_W;
    mul_b   = '0;
    mul_sh  = 20;
    mn      = '0;
    unique case (state_r)
      L_NEED: begin
        is_div  = 1'b1;
        div_num = 64'(dq_mag) << 17;
        div_den = TIME_W'(spd);
      end
      L_QA: begin
        is_div  = 1'b1;
        div_num = (64'(dq_mag) * 64'd3) << 16;
        div_neg = dq[ANG_W];
      end
      L_QB: begin
        is_div  = 1'b1;
        div_num = (64'(dq_mag) * 64'd2) << 16;
        div_neg = dq[ANG_W];
      end
      L_C: begin
        is_div  = 1'b1;
        mn      = mag64(64'(a_r));
        div_num = ((mn > CAP31) ? CAP31 : mn) << 32;
        div_neg = a_r[ACC_W-1];
      end
      L_U: begin
        is_div  = 1'b1;
        mn      = mag64(64'(b_r));
        div_num = ((mn > CAP31) ? CAP31 : mn) << 32;
        div_neg = b_r[ACC_W-1];
        div_w   = U_W;
      end
      L_D: begin
        is_div  = 1'b1;
        mn      = mag64(64'(u_r));
        div_num = ((mn > CAP43) ? CAP43 : mn) << 20;
        div_neg = u_r[U_W-1];
      end
      L_E: mul_b = ccu_r;
      L_G: mul_b = COEF_W'(clamp_s(64'(csq_r) + 64'(e_r), COEF_W));
      L_P: begin
        mul_b  = g_r;
        mul_sh = 28;
      end
      L_V: begin
        mul_b  = COEF_W'(clamp_s(64'(csq_r) * 2 + 64'(e_r) * 3, COEF_W));
        mul_sh = 32;
      end
      default: ;
    endcase
    div_start = is_div && !issued_r;
    mul_start = !is_div && !issued_r && (state_r != L_IDLE) && (state_r != L_FIN);
    unit_done = is_div ? div_done : mul_done;
  end

  assign q_rnd  = div_q + 64'({div_rem, 1'b0} >= {1'b0, div_den});
  assign q_ceil = div_q + 64'(div_rem != '0);
  assign qs     = sat_from(div_neg, q_rnd, div_w);
  assign mp     = sat_from(mul_neg, rnd_shr(mul_p, mul_sh), COEF_W);

  csmg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .rem   (div_rem),
    .done  (div_done)
  );

  csmg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (t),
    .b     (mul_b),
    .p     (mul_p),
    .neg   (mul_neg),
    .done  (mul_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= L_IDLE;
      issued_r <= 1'b0;
      pos_r    <= HOME_POS[LANE];
      vel_r    <= '0;
      cst_r    <= '0;
      csq_r    <= '0;
      ccu_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= (state_nxt == state_r) && (state_r != L_IDLE) && (state_r != L_FIN);
      if (state_r == L_IDLE && cmd.coef) begin
        cst_r <= tgt_r;
        csq_r <= '0;
        ccu_r <= '0;
      end
      if (issued_r && unit_done) begin
        unique case (state_r)
          L_C:     csq_r <= qs[COEF_W-1:0];
          L_D:     ccu_r <= qs[COEF_W-1:0];
          L_P:     pos_r <= ANG_W'(clamp_s(64'(cst_r) + mp, ANG_W));
          L_V:     vel_r <= ANG_W'(clamp_s(mp, ANG_W));
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && cmd.need) begin
      tgt_r <= tgt_in;
    end
    if (issued_r && unit_done) begin
      unique case (state_r)
        L_NEED:  need_r <= (q_ceil > 64'hFF_FFFF) ? '1 : q_ceil[TIME_W-1:0];
        L_QA:    a_r    <= ACC_W'(qs) + ACC_W'(vel_r);
        L_QB:    b_r    <= ACC_W'(qs) + ACC_W'(vel_r);
        L_U:     u_r    <= qs[U_W-1:0];
        L_E:     e_r    <= mp[COEF_W-1:0];
        L_G:     g_r    <= mp[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign sts = '{done: (state_r == L_FIN), need: need_r};
  assign pos = pos_r;
  assign vel = vel_r;

endmodule

`default_nettype wire

// File: rtl/core/cubic_spline_move_generator.sv
// Cubic spline move generator: one joint lane per joint and the merging,
// move-clock and stream control logic. Uses csmg_pkg and csmg_lane.
//
// Usage. Input beats carry the operation in in_tuser (load or tick) and the
// target angles in in_tdata. A load picks the move time as the largest of
// min_move_time and every joint's need, then computes each joint's cubic
// coefficients; a tick advances the move clock by tick_period, holding it at
// zero, and evaluates every joint's position and velocity. Each input beat
// gives exactly one output beat. Lanes work in parallel; each owns a one bit
// per cycle divider and a partial-product multiplier. A load runs six
// 64-step divisions per lane (one for the move time, five for the
// coefficients) in series. A tick runs four multiplications per lane in
// series. One item is in flight at a time; in_tready is high when the
// block is free, even while a finished beat waits in the output register.
// If the receiver stalls, the block holds the next result until the output
// register drains.
// Reset restores the register defaults, the home joint angles, zero velocity
// and coefficients and a zero move clock. The configuration port is always
// ready; the user must write it only while the block is idle (unenforced).
`default_nettype none

module cubic_spline_move_generator #(
  parameter int unsigned NUM_JOINTS = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // target_0 .. target_(NUM_JOINTS-1), 16 bits each from bit 0 up
  input  wire logic [16*NUM_JOINTS-1:0]              in_tdata,
  // operation
  input  wire logic                                  in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // move_time (24), position_0 .. position_(N-1), velocity_0 .. velocity_(N-1)
  output logic [24+32*NUM_JOINTS-1:0]                out_tdata,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [csmg_pkg::IDX_W-1:0]            cfg_index,
  input  wire logic [csmg_pkg::CFG_W-1:0]            cfg_data
);
  import csmg_pkg::*;

  localparam int unsigned OUT_W = TIME_W + 2 * ANG_W * NUM_JOINTS;

  top_st_t state_r, state_nxt;

  logic [SPD_W-1:0]  spd_r, spd_eff;
  logic [TIME_W-1:0] min_t_r, tm_r, tm_merge;
  logic [TICK_W-1:0] tick_r;
  logic signed [CLK_W-1:0] mc_r;
  logic signed [CLK_W:0]   mc_sum;
  logic                    is_load_r, out_tvalid_r, accept, all_done, load_out;
  logic [OUT_W-1:0]        out_tdata_r, out_word;

  lane_cmd_t               cmd;
  lane_sts_t               sts_w [NUM_JOINTS];
  logic [NUM_JOINTS-1:0]   done_w;
  logic signed [ANG_W-1:0] pos_w [NUM_JOINTS];
  logic signed [ANG_W-1:0] vel_w [NUM_JOINTS];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign spd_eff   = (spd_r == '0) ? SPD_W'(1) : spd_r;
  assign all_done  = &done_w;

  assign cmd = '{need: accept && (in_tuser == OP_LOAD),
                 coef: (state_r == T_CGO),
                 tick: accept && (in_tuser == OP_TICK)};

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
    csmg_lane #(.LANE(j)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .sts    (sts_w[j]),
      .tgt_in (in_tdata[ANG_W*j +: ANG_W]),
      .spd    (spd_eff),
      .tm     (tm_r),
      .t      (mc_r),
      .pos    (pos_w[j]),
      .vel    (vel_w[j])
    );
    assign done_w[j] = sts_w[j].done;
  end

  always_comb begin
    tm_merge = min_t_r;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      if (sts_w[j].need > tm_merge) tm_merge = sts_w[j].need;
    end
  end

  assign mc_sum = (CLK_W + 1)'(mc_r) + (CLK_W + 1)'($signed({1'b0, tick_r}));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (accept) state_nxt = (in_tuser == OP_LOAD) ? T_NEED : T_TICK;
      T_NEED:  if (all_done) state_nxt = T_MERGE;
      T_MERGE: state_nxt = T_CGO;
      T_CGO:   state_nxt = T_COEF;
      T_COEF:  if (all_done) state_nxt = T_OUT;
      T_TICK:  if (all_done) state_nxt = T_OUT;
      T_OUT:   if (!out_tvalid_r || out_tready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    load_out = (state_r == T_OUT) && (!out_tvalid_r || out_tready);
    out_word = '0;
    out_word[TIME_W-1:0] = is_load_r ? tm_r : '0;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      out_word[TIME_W + ANG_W*j +: ANG_W]                  = pos_w[j];
      out_word[TIME_W + ANG_W*(NUM_JOINTS + j) +: ANG_W]   = vel_w[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      spd_r        <= SPEED_RST;
      min_t_r      <= MIN_TIME_RST;
      tick_r       <= TICK_RST;
      mc_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SPEED:    spd_r   <= cfg_data[SPD_W-1:0];
          REG_MIN_TIME: min_t_r <= cfg_data[TIME_W-1:0];
          REG_TICK:     tick_r  <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.tick) begin
        mc_r <= (mc_sum > 0) ? '0 : mc_sum[CLK_W-1:0];
      end else if (state_r == T_CGO) begin
        mc_r <= -$signed({1'b0, tm_r});
      end
      if (load_out) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) is_load_r <= (in_tuser == OP_LOAD);
    if (state_r == T_MERGE) tm_r <= tm_merge;
    if (load_out) out_tdata_r <= out_word;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_clock_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mc_r > 0))
    else $error("move clock above zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat taken while busy");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (|done_w) |-> (&done_w))
    else $error("lanes finished out of step");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (|done_w) |-> (state_r == T_NEED || state_r == T_COEF || state_r == T_TICK))
    else $error("lane finished while controller not waiting");

endmodule

`default_nettype wire

// File: bench/csmg_checker.sv
// Checker for the cubic spline move generator: watches the configuration, input and
// result channels, predicts every result beat and compares it field by field.
// Depends on csmg_pkg for the operation and register codes and the home angles.
module csmg_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [63:0]  in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [151:0] out_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_data,
  output int                fails,
  output int                pending
);
  import csmg_pkg::*;

  localparam longint LIM40 = 64'sh7F_FFFF_FFFF;
  localparam longint LIM44 = 64'sh7FF_FFFF_FFFF;
  localparam longint MAXT  = 64'sh FF_FFFF;

  bit [63:0] speed_limit, min_time, tick_step;
  longint    clock_now;
  longint    ang [4];
  longint    rate [4];
  longint    goal [4];
  longint    sq_coef [4];
  longint    cube_coef [4];
  bit [151:0] beats_due [$];

  assign pending = beats_due.size();

  function automatic bit [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint from_mag(input bit neg, input bit [63:0] m, input longint lim);
    if (m > 64'(lim)) return neg ? -lim - 1 : lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  function automatic longint div_round(input longint n, input int sh, input bit [63:0] den,
                                       input longint lim);
    bit [63:0] m, cap, num, q;
    m = mag(n);
    cap = (64'd1 << (63 - sh)) - 64'd1;
    if (m > cap) m = cap;
    num = m << sh;
    q = num / den;
    if ((num % den) * 2 >= den) q++;
    return from_mag(n < 0, q, lim);
  endfunction

  function automatic longint mul_round(input longint a, input longint b, input int sh,
                                       input longint lim);
    bit [63:0] p, r;
    p = mag(a) * mag(b);
    r = (p >> sh) + ((p >> (sh - 1)) & 64'd1);
    return from_mag((a < 0) != (b < 0), r, lim);
  endfunction

  function automatic bit [23:0] field_of(input bit [151:0] v, input int k);
    if (k == 0) return v[23:0];
    return {8'd0, v[24 + 16 * (k - 1) +: 16]};
  endfunction

  task automatic predict_beat(input logic op, input logic [63:0] tgts);
    bit [63:0] spd, tm, m, need;
    longint    tg [4];
    longint    dq, a, b, u, t, e, h, g, s;
    bit [151:0] res;
    tm = 0;
    if (op == OP_LOAD) begin
      spd = speed_limit != 0 ? speed_limit : 64'd1;
      tm = min_time;
      for (int j = 0; j < 4; j++) begin
        tg[j] = longint'($signed(tgts[16 * j +: 16]));
        m = mag(ang[j] - tg[j]);
        need = ((m << 17) + spd - 1) / spd;
        if (need > 64'(MAXT)) need = 64'(MAXT);
        if (need > tm) tm = need;
      end
      for (int j = 0; j < 4; j++) begin
        dq = ang[j] - tg[j];
        goal[j] = tg[j];
        if (tm == 0) begin
          sq_coef[j] = 0;
          cube_coef[j] = 0;
        end else begin
          a = div_round(3 * dq, 16, tm, LIM40) + rate[j];
          b = div_round(2 * dq, 16, tm, LIM40) + rate[j];
          u = div_round(b, 32, tm, LIM44);
          sq_coef[j] = div_round(a, 32, tm, LIM40);
          cube_coef[j] = div_round(u, 20, tm, LIM40);
        end
      end
      clock_now = -longint'(tm);
    end else begin
      clock_now += longint'(tick_step);
      if (clock_now > 0) clock_now = 0;
      t = clock_now;
      for (int j = 0; j < 4; j++) begin
        e = mul_round(t, cube_coef[j], 20, LIM40);
        h = clip(sq_coef[j] + e, LIM40);
        g = mul_round(t, h, 20, LIM40);
        s = clip(2 * sq_coef[j] + 3 * e, LIM40);
        ang[j] = clip(goal[j] + mul_round(t, g, 28, LIM40), 32767);
        rate[j] = clip(mul_round(t, s, 32, LIM40), 32767);
      end
    end
    res = '0;
    res[23:0] = tm[23:0];
    for (int j = 0; j < 4; j++) begin
      res[24 + 16 * j +: 16] = ang[j][15:0];
      res[88 + 16 * j +: 16] = rate[j][15:0];
    end
    beats_due = {beats_due, res};
  endtask

  string names [9] = '{"move_time", "position_0", "position_1", "position_2", "position_3",
                       "velocity_0", "velocity_1", "velocity_2", "velocity_3"};

  always @(posedge clk) begin
    bit [151:0] want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      fails <= 0;
      speed_limit = 64'(SPEED_RST);
      min_time = 64'(MIN_TIME_RST);
      tick_step = 64'(TICK_RST);
      clock_now = 0;
      for (int j = 0; j < 4; j++) begin
        ang[j] = longint'(HOME_POS[j]);
        rate[j] = 0;
        goal[j] = 0;
        sq_coef[j] = 0;
        cube_coef[j] = 0;
      end
      beats_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED:    speed_limit = 64'(cfg_data[14:0]);
          REG_MIN_TIME: min_time = 64'(cfg_data);
          REG_TICK:     tick_step = 64'(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (beats_due.size() == 0) begin
          $display("%0t: result beat with none expected, got %h", $time, out_tdata);
          bad++;
        end else begin
          want = beats_due.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (field_of(want, k) !== field_of(out_tdata, k)) begin
              $display("%0t: %s expected %h, got %h", $time, names[k],
                       field_of(want, k), field_of(out_tdata, k));
              bad++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) predict_beat(in_tuser, in_tdata);
      fails <= fails + bad;
    end
  end
endmodule

// File: bench/tb_cubic_spline_move_generator.sv
// Testbench top for the cubic spline move generator: drives configuration, load and
// tick beats with random gaps and stalls. Depends on csmg_pkg, csmg_checker and the DUT.
module tb_cubic_spline_move_generator;
  import csmg_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;
  int           fails;
  int           pending;
  int           burst_left = 0;
  int           cycles = 0;
  logic [7:0]   stall_cnt = '0;
  int           stall_mode = 0;

  always #4 clk = ~clk;

  cubic_spline_move_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  csmg_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 8'd1;
    if (stall_cnt == 8'd0) stall_mode <= $urandom_range(3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(1));
      2: out_tready <= (stall_cnt[1:0] == 2'd0);
      default: out_tready <= (stall_cnt[5:0] > 6'd40);
    endcase
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic op, input logic [63:0] tg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= tg;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_targets();
    logic [63:0] v;
    logic [15:0] base;
    v = {$urandom(), $urandom()};
    if ($urandom_range(2) == 0) begin
      base = 16'($urandom());
      for (int j = 0; j < 4; j++) v[16 * j +: 16] = base + 16'($urandom_range(0, 512)) - 16'd256;
    end
    return v;
  endfunction

  task automatic tick_run(input int n);
    repeat (n) send_beat(OP_TICK, {$urandom(), $urandom()});
  endtask

  initial begin
    logic [23:0] v;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero move time: no minimum and the home angles loaded again.
    write_reg(REG_MIN_TIME, 24'd0);
    send_beat(OP_LOAD, {16'sd0, 16'sd7168, 16'sd3686, 16'sd0});
    tick_run(2);
    drain();

    write_reg(REG_MIN_TIME, 24'd4096);
    write_reg(REG_SPEED, 24'd32767);
    write_reg(REG_TICK, 24'd65535);
    send_beat(OP_LOAD, {4{16'h7FFF}});
    tick_run(3);
    send_beat(OP_LOAD, {4{16'h8000}});
    send_beat(OP_LOAD, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
    tick_run(4);
    drain();

    // Zero speed limit counts as one; a zero tick period freezes the clock.
    write_reg(REG_SPEED, 24'd0);
    write_reg(REG_TICK, 24'd0);
    send_beat(OP_LOAD, {16'h1234, 16'hEDCB, 16'h0400, 16'hFC00});
    tick_run(3);
    drain();

    write_reg(REG_SPEED, 24'd1);
    write_reg(REG_MIN_TIME, 24'hFFFFFF);
    write_reg(REG_TICK, 24'd1);
    send_beat(OP_LOAD, {4{16'h7FFF}});
    tick_run(3);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(2))
        0: v = 24'd1;
        1: v = 24'd32767;
        default: v = 24'($urandom_range(1, 32767));
      endcase
      write_reg(REG_SPEED, v);
      case ($urandom_range(3))
        0: v = 24'd0;
        1: v = 24'hFFFFFF;
        default: v = 24'($urandom_range(0, 1 << 20));
      endcase
      write_reg(REG_MIN_TIME, v);
      case ($urandom_range(4))
        0: v = 24'd1;
        1: v = 24'd65535;
        2: v = 24'd0;
        default: v = 24'($urandom_range(1, 8192));
      endcase
      write_reg(REG_TICK, v);
      for (int n = 0; n < 110; ) begin
        int k;
        k = $urandom_range(1, 25);
        send_beat(OP_LOAD, rand_targets());
        tick_run(k);
        n += k + 1;
      end
      drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
